>>> rtl/ptns_pkg.sv
// Shared constants, codes and types of the point table nearest search.
package ptns_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int CORNERS    = 4;
  localparam int IDX_W      = $clog2(MAX_POINTS + CORNERS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_W       = ((OP_W + IDX_W + 2 * COORD_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_W      = ((STATUS_W + 2 * IDX_W + 2 * COORD_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE    = 3'd2;
  localparam logic [OP_W-1:0] OP_NEAREST = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PROTECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One candidate point travelling through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
  } ptns_tag_t;

endpackage

>>> rtl/ptns_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module ptns_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ptns_dist.sv
// Three-stage pipeline giving the exact squared distance of a point to the query.
module ptns_dist (
  input  logic                     clk,
  input  logic                     rst,
  input  ptns_pkg::ptns_tag_t      in_tag,
  input  ptns_pkg::coord_t         qx,
  input  ptns_pkg::coord_t         qy,
  output ptns_pkg::ptns_tag_t      out_tag,
  output logic [ptns_pkg::DIST_W-1:0] dist_sq
);
  import ptns_pkg::*;

  ptns_tag_t               tag_a;
  ptns_tag_t               tag_b;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]       ax;
  logic [DIFF_W-1:0]       ay;
  logic [SQ_W-1:0]         sqx;
  logic [SQ_W-1:0]         sqy;

  always_comb begin
    ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a.valid   <= 1'b0;
      tag_b.valid   <= 1'b0;
      out_tag.valid <= 1'b0;
    end else begin
      tag_a   <= in_tag;
      tag_b   <= tag_a;
      out_tag <= tag_b;
    end
    dx      <= DIFF_W'(in_tag.x) - DIFF_W'(qx);
    dy      <= DIFF_W'(in_tag.y) - DIFF_W'(qy);
    sqx     <= SQ_W'(ax) * SQ_W'(ax);
    sqy     <= SQ_W'(ay) * SQ_W'(ay);
    dist_sq <= DIST_W'(sqx) + DIST_W'(sqy);
  end

endmodule

>>> rtl/point_table_nearest_search.sv
// Top level of the point table with insert, delete, move, read and nearest search.
// A table of 2D points: indices 0 to 3 are the rectangle corners from the
// configuration registers, user points follow packed from index 4. Every input
// beat yields exactly one result beat. Delete shifts the later points down
// through the point RAM, reading and then writing each moved entry; nearest
// streams each candidate through the RAM read and a three-stage distance
// pipeline at one entry per cycle. The next beat is taken as soon as the
// result sits in the output register.
module point_table_nearest_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // operation, point_index, coord_x, coord_y, include_corners, zero fill
  input  logic [ptns_pkg::IN_W-1:0]      s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, result_index, out_x, out_y, points_held, zero fill
  output logic [ptns_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptns_pkg::COORD_BITS-1:0] cfg_data
);
  import ptns_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ_WAIT, S_DEL_RD, S_DEL_WR, S_SCAN, S_DRAIN, S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] CORNERS_I = IDX_W'(CORNERS);
  localparam logic [IDX_W-1:0] FULL_I    = IDX_W'(MAX_POINTS + CORNERS);

  state_t               state;
  coord_t               x_min, x_max, y_min, y_max;
  logic [IDX_W-1:0]     point_count;
  coord_t               qx, qy;
  logic [ADDR_W-1:0]    del_ptr;
  logic [IDX_W-1:0]     scan_i;
  logic [2:0]           drain;
  logic [STATUS_W-1:0]  res_status;
  logic [IDX_W-1:0]     res_idx;
  coord_t               res_x, res_y;
  logic                 found;
  logic [DIST_W-1:0]    best_dist;
  ptns_tag_t            best;
  ptns_tag_t            s1_tag;
  logic                 s1_corner;
  ptns_tag_t            dist_in;
  ptns_tag_t            dist_out;
  logic [DIST_W-1:0]    dist_sq;

  logic                 accept;
  logic [OP_W-1:0]      in_op;
  logic [IDX_W-1:0]     in_idx;
  coord_t               in_x, in_y;
  logic                 in_corners;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [2*COORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [2*COORD_BITS-1:0] ram_rdata;
  coord_t               ram_x, ram_y;
  logic [IDX_W-1:0]     count_off;
  logic [IDX_W-1:0]     idx_off;
  logic [IDX_W-1:0]     del_next;
  logic [IDX_W-1:0]     scan_off;

  assign s_tready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = s_tvalid && s_tready;
  assign in_op      = s_tdata[OP_W-1:0];
  assign in_idx     = s_tdata[OP_W +: IDX_W];
  assign in_x       = s_tdata[OP_W+IDX_W +: COORD_BITS];
  assign in_y       = s_tdata[OP_W+IDX_W+COORD_BITS +: COORD_BITS];
  assign in_corners = s_tdata[OP_W+IDX_W+2*COORD_BITS];
  assign count_off  = point_count - CORNERS_I;
  assign idx_off    = in_idx - CORNERS_I;
  assign del_next   = IDX_W'(del_ptr) + IDX_W'(1);
  assign scan_off   = scan_i - CORNERS_I;
  assign ram_x      = ram_rdata[COORD_BITS-1:0];
  assign ram_y      = ram_rdata[2*COORD_BITS-1:COORD_BITS];

  function automatic coord_t corner_x(input logic [IDX_W-1:0] i);
    corner_x = (i < IDX_W'(2)) ? x_min : x_max;
  endfunction

  function automatic coord_t corner_y(input logic [IDX_W-1:0] i);
    corner_y = (i == IDX_W'(0) || i == IDX_W'(3)) ? y_min : y_max;
  endfunction

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_off[ADDR_W-1:0];
    ram_wdata = {in_y, in_x};
    ram_raddr = idx_off[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && in_op == OP_INSERT && point_count != FULL_I) begin
          ram_we = 1'b1;
        end else if (accept && in_op == OP_MOVE && in_idx >= CORNERS_I
                     && in_idx < point_count) begin
          ram_we    = 1'b1;
          ram_waddr = idx_off[ADDR_W-1:0];
        end
      end
      S_DEL_RD: ram_raddr = del_next[ADDR_W-1:0];
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = del_ptr;
        ram_wdata = ram_rdata;
      end
      S_SCAN: ram_raddr = scan_off[ADDR_W-1:0];
      default: ;
    endcase
  end

  ptns_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    dist_in = s1_tag;
    if (!s1_corner) begin
      dist_in.x = ram_x;
      dist_in.y = ram_y;
    end
  end

  ptns_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (dist_in),
    .qx      (qx),
    .qy      (qy),
    .out_tag (dist_out),
    .dist_sq (dist_sq)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      x_max <= {1'b0, {(COORD_BITS-1){1'b1}}};
      y_min <= '0;
      y_max <= {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_MIN: x_min <= cfg_data;
        REG_X_MAX: x_max <= cfg_data;
        REG_Y_MIN: y_min <= cfg_data;
        REG_Y_MAX: y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= CORNERS_I;
      m_tvalid     <= 1'b0;
      s1_tag.valid <= 1'b0;
      found        <= 1'b0;
    end else begin
      s1_tag.valid <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (dist_out.valid && (!found || dist_sq < best_dist)) begin
        found     <= 1'b1;
        best_dist <= dist_sq;
        best      <= dist_out;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qx         <= in_x;
            qy         <= in_y;
            res_status <= ST_OK;
            res_idx    <= '0;
            res_x      <= '0;
            res_y      <= '0;
            state      <= S_DONE;
            case (in_op)
              OP_INSERT: begin
                if (point_count == FULL_I) begin
                  res_status <= ST_FULL;
                end else begin
                  res_idx     <= point_count;
                  point_count <= point_count + IDX_W'(1);
                end
              end
              OP_DELETE, OP_MOVE: begin
                if (in_idx < CORNERS_I) begin
                  res_status <= ST_PROTECTED;
                end else if (in_idx >= point_count) begin
                  res_status <= ST_RANGE;
                end else if (in_op == OP_DELETE) begin
                  del_ptr <= idx_off[ADDR_W-1:0];
                  state   <= S_DEL_RD;
                end
              end
              OP_NEAREST: begin
                scan_i <= in_corners ? '0 : CORNERS_I;
                found  <= 1'b0;
                state  <= S_SCAN;
              end
              OP_READ: begin
                if (in_idx >= point_count) begin
                  res_status <= ST_RANGE;
                end else if (in_idx < CORNERS_I) begin
                  res_x <= corner_x(in_idx);
                  res_y <= corner_y(in_idx);
                end else begin
                  state <= S_READ_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ_WAIT: begin
          res_x <= ram_x;
          res_y <= ram_y;
          state <= S_DONE;
        end
        S_DEL_RD: begin
          if (del_next < count_off) begin
            state <= S_DEL_WR;
          end else begin
            point_count <= point_count - IDX_W'(1);
            state       <= S_DONE;
          end
        end
        S_DEL_WR: begin
          del_ptr <= del_next[ADDR_W-1:0];
          state   <= S_DEL_RD;
        end
        S_SCAN: begin
          if (scan_i < point_count) begin
            s1_tag.valid <= 1'b1;
            s1_tag.idx   <= scan_i;
            s1_tag.x     <= corner_x(scan_i);
            s1_tag.y     <= corner_y(scan_i);
            s1_corner    <= (scan_i < CORNERS_I);
            scan_i       <= scan_i + IDX_W'(1);
          end else begin
            drain <= 3'd5;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Candidates still in the RAM read and distance stages land here.
          if (drain == 3'd0) begin
            if (found) begin
              res_idx <= best.idx;
              res_x   <= best.x;
              res_y   <= best.y;
            end else begin
              res_status <= ST_NONE;
            end
            state <= S_DONE;
          end else begin
            drain <= drain - 3'd1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({point_count, res_y, res_x, res_idx, res_status});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    point_count >= CORNERS_I && point_count <= FULL_I)
    else $error("point count left its range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (point_count == $past(point_count) || point_count == $past(point_count) + IDX_W'(1)
         || point_count == $past(point_count) - IDX_W'(1)))
    else $error("point count changed by more than one");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |-> !ram_we)
    else $error("point RAM written during a nearest search");

  a_scan_feed: assert property (@(posedge clk) disable iff (rst)
    s1_tag.valid |-> $past(state) == S_SCAN)
    else $error("candidate issued outside a search");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the point table nearest search block.
`timescale 1ns / 100ps

module testbench;
  import ptns_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 160;
  localparam int ITEMS_PER_PHASE = 215;
  localparam coord_t C_MIN = -24'sd8388608;
  localparam coord_t C_MAX = 24'sd8388607;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    ridx;
    coord_t              ox;
    coord_t              oy;
    logic [IDX_W-1:0]    held;
  } answer_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
    logic             inc;
    logic             typed;
    answer_t          ans;
  } request_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0] s_tdata;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  point_table_nearest_search dut (.*);

  // Shadow copy of the table and the rectangle.
  coord_t edge_x_min, edge_x_max, edge_y_min, edge_y_max;
  coord_t shadow_x [MAX_POINTS];
  coord_t shadow_y [MAX_POINTS];
  int unsigned shadow_count;

  answer_t pending_answers[$];
  request_t directed_rows[$];
  int errors = 0;
  int cycles = 0;
  bit idling = 1;
  bit hold_req = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void corner_point(int unsigned i, output coord_t px, output coord_t py);
    if (i < CORNERS) begin
      px = (i < 2) ? edge_x_min : edge_x_max;
      py = (i == 0 || i == 3) ? edge_y_min : edge_y_max;
    end else begin
      px = shadow_x[i - CORNERS];
      py = shadow_y[i - CORNERS];
    end
  endfunction

  // Applies one accepted request to the shadow table and returns its answer.
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    coord_t px, py;
    longint dx, dy, d, best_d;
    int unsigned best;
    bit found;
    a = '0;
    case (r.op)
      OP_INSERT: begin
        if (shadow_count >= MAX_POINTS + CORNERS) a.status = ST_FULL;
        else begin
          shadow_x[shadow_count - CORNERS] = r.x;
          shadow_y[shadow_count - CORNERS] = r.y;
          a.ridx = IDX_W'(shadow_count);
          shadow_count++;
        end
      end
      OP_DELETE, OP_MOVE: begin
        if (r.idx < CORNERS) a.status = ST_PROTECTED;
        else if (r.idx >= shadow_count) a.status = ST_RANGE;
        else if (r.op == OP_MOVE) begin
          shadow_x[r.idx - CORNERS] = r.x;
          shadow_y[r.idx - CORNERS] = r.y;
        end else begin
          for (int unsigned i = r.idx - CORNERS; i + 1 < shadow_count - CORNERS; i++) begin
            shadow_x[i] = shadow_x[i + 1];
            shadow_y[i] = shadow_y[i + 1];
          end
          shadow_count--;
        end
      end
      OP_NEAREST: begin
        found = 0;
        best = 0;
        best_d = 0;
        for (int unsigned i = r.inc ? 0 : CORNERS; i < shadow_count; i++) begin
          corner_point(i, px, py);
          dx = longint'(px) - longint'(r.x);
          dy = longint'(py) - longint'(r.y);
          d = dx * dx + dy * dy;
          if (!found || d < best_d) begin
            found = 1;
            best_d = d;
            best = i;
          end
        end
        if (found) begin
          corner_point(best, px, py);
          a.ridx = IDX_W'(best);
          a.ox = px;
          a.oy = py;
        end else a.status = ST_NONE;
      end
      OP_READ: begin
        if (r.idx >= shadow_count) a.status = ST_RANGE;
        else begin
          corner_point(r.idx, px, py);
          a.ox = px;
          a.oy = py;
        end
      end
      default: ;
    endcase
    a.held = IDX_W'(shadow_count);
    return a;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(request_t r);
    answer_t a;
    bit ok;
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, r.inc, r.y, r.x, r.idx, r.op};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    a = apply_request(r);
    pending_answers.push_back(r.typed ? r.ans : a);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      idle_cycles($urandom_range(1, 12));
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input coord_t value);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    case (index)
      REG_X_MIN: edge_x_min = value;
      REG_X_MAX: edge_x_max = value;
      REG_Y_MIN: edge_y_min = value;
      default:   edge_y_max = value;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    idle_cycles(DRAIN_CYCLES);
  endtask

  function automatic request_t make_row(logic [OP_W-1:0] op, int idx, coord_t x, coord_t y,
                                        logic inc, logic typed, answer_t ans);
    request_t r;
    r.op = op; r.idx = IDX_W'(idx); r.x = x; r.y = y; r.inc = inc; r.typed = typed;
    r.ans = ans;
    return r;
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return coord_t'($urandom_range(0, 64)) - 24'sd32;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic request_t random_request(int insert_weight);
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < insert_weight) r.op = OP_INSERT;
    else if (pick < insert_weight + 12) r.op = OP_DELETE;
    else if (pick < insert_weight + 24) r.op = OP_MOVE;
    else if (pick < insert_weight + 50) r.op = OP_NEAREST;
    else if (pick < 97) r.op = OP_READ;
    else r.op = OP_W'($urandom_range(5, 7));
    if ($urandom_range(0, 4) == 0) r.idx = IDX_W'($urandom_range(0, 127));
    else r.idx = IDX_W'($urandom_range(0, shadow_count));
    r.x = random_coord();
    r.y = random_coord();
    r.inc = 1'($urandom_range(0, 1));
    r.typed = 0;
    r.ans = '0;
    return r;
  endfunction

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        idle_cycles(400);
        hold_req = 0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        idle_cycles($urandom_range(1, 12));
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[STATUS_W-1:0];
      got.ridx   = m_tdata[STATUS_W +: IDX_W];
      got.ox     = m_tdata[STATUS_W+IDX_W +: COORD_BITS];
      got.oy     = m_tdata[STATUS_W+IDX_W+COORD_BITS +: COORD_BITS];
      got.held   = m_tdata[STATUS_W+IDX_W+2*COORD_BITS +: IDX_W];
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.ridx !== want.ridx) begin
          $error("result_index expected %0d actual %0d", want.ridx, got.ridx); errors++;
        end
        if (got.ox !== want.ox) begin
          $error("out_x expected %0d actual %0d", want.ox, got.ox); errors++;
        end
        if (got.oy !== want.oy) begin
          $error("out_y expected %0d actual %0d", want.oy, got.oy); errors++;
        end
        if (got.held !== want.held) begin
          $error("points_held expected %0d actual %0d", want.held, got.held); errors++;
        end
      end
    end
  end

  initial begin
    int insert_weight;
    coord_t v;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    edge_x_min = '0; edge_x_max = C_MAX; edge_y_min = '0; edge_y_max = C_MAX;
    shadow_count = CORNERS;
    foreach (shadow_x[i]) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: reset state, protection, range errors, extremes, spare codes.
    directed_rows.push_back(make_row(OP_READ, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_READ, 2, 0, 0, 0, 1, '{ST_OK, 0, C_MAX, C_MAX, 4}));
    directed_rows.push_back(make_row(OP_READ, 3, 0, 0, 0, 1, '{ST_OK, 0, C_MAX, 0, 4}));
    directed_rows.push_back(make_row(OP_NEAREST, 0, 5, 5, 0, 1, '{ST_NONE, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_NEAREST, 0, 5, 5, 1, 1, '{ST_OK, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_DELETE, 0, 0, 0, 0, 1, '{ST_PROTECTED, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_MOVE, 3, 1, 1, 0, 1, '{ST_PROTECTED, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_READ, 4, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_DELETE, 127, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_MOVE, 4, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 4}));
    directed_rows.push_back(make_row(OP_INSERT, 0, C_MIN, C_MIN, 0, 1, '{ST_OK, 4, 0, 0, 5}));
    directed_rows.push_back(make_row(OP_INSERT, 0, C_MAX, C_MAX, 0, 1, '{ST_OK, 5, 0, 0, 6}));
    directed_rows.push_back(make_row(OP_READ, 4, 0, 0, 0, 1, '{ST_OK, 0, C_MIN, C_MIN, 6}));
    directed_rows.push_back(make_row(OP_READ, 5, 0, 0, 0, 1, '{ST_OK, 0, C_MAX, C_MAX, 6}));
    directed_rows.push_back(make_row(OP_NEAREST, 0, C_MIN, C_MAX, 0, 0, '0));
    directed_rows.push_back(make_row(OP_NEAREST, 0, C_MAX, C_MAX, 1, 0, '0));
    directed_rows.push_back(make_row(OP_INSERT, 0, 100, -100, 0, 0, '0));
    directed_rows.push_back(make_row(OP_MOVE, 5, -7, 7, 0, 0, '0));
    directed_rows.push_back(make_row(OP_DELETE, 4, 0, 0, 0, 0, '0));
    directed_rows.push_back(make_row(OP_NEAREST, 0, 0, 0, 0, 0, '0));
    directed_rows.push_back(make_row(OP_SPARE_5, 127, C_MAX, C_MAX, 1, 1, '{ST_OK, 0, 0, 0, 6}));
    directed_rows.push_back(make_row(OP_SPARE_6, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 6}));
    directed_rows.push_back(make_row(OP_SPARE_7, 0, C_MIN, C_MIN, 0, 1, '{ST_OK, 0, 0, 0, 6}));
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    wait_quiet();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_register(REG_X_MIN, C_MIN); write_register(REG_X_MAX, C_MAX);
          write_register(REG_Y_MIN, C_MIN); write_register(REG_Y_MAX, C_MAX);
        end
        2: begin
          v = coord_t'($urandom());
          write_register(REG_X_MIN, v); write_register(REG_Y_MAX, coord_t'($urandom()));
          write_register(REG_X_MAX, coord_t'($urandom())); write_register(REG_Y_MIN, v);
        end
        3: begin
          write_register(REG_X_MIN, C_MAX); write_register(REG_X_MAX, C_MIN);
          write_register(REG_Y_MIN, C_MAX); write_register(REG_Y_MAX, C_MIN);
        end
        4: begin
          // Coincident corners make every corner tie on distance.
          write_register(REG_X_MIN, '0); write_register(REG_X_MAX, '0);
          write_register(REG_Y_MIN, '0); write_register(REG_Y_MAX, '0);
        end
        default: ;
      endcase
      insert_weight = (phase == 1) ? 60 : (phase == 3 ? 10 : 30);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 40) hold_req = 1;
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) idling = 0;
        send_request(random_request(insert_weight));
      end
      // The sender pauses here until every result has arrived.
      wait_quiet();
    end

    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
